// ===== rtl/azr_pkg.sv =====
package azr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int FX_W      = 16;
  localparam int THR_W     = 15;
  localparam int ACC_W     = 36;
  localparam int SQ_STEPS  = 16;
  localparam int DIV_STEPS = 15;

  localparam logic [ACC_W-1:0] ONE_FX  = ACC_W'(1) << FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF_FX = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] ONE_SQ  = ACC_W'(1) << (2 * FRAC_BITS);

  // digit-by-digit square root, two radicand bits per step
  typedef struct packed {
    logic [31:0] x;
    logic [17:0] rem;
    logic [15:0] root;
  } sqrt_t;

  // restoring divide, one quotient bit per step
  typedef struct packed {
    logic [14:0] num;
    logic [16:0] rem;
    logic [14:0] q;
  } div_t;

  function automatic sqrt_t sqrt_step(input sqrt_t a);
    sqrt_t       b;
    logic [19:0] r;
    logic [19:0] t;
    r   = {a.rem, a.x[31:30]};
    t   = {2'b00, a.root, 2'b01};
    b.x = {a.x[29:0], 2'b00};
    if (r >= t) begin
      b.rem  = 18'(r - t);
      b.root = {a.root[14:0], 1'b1};
    end else begin
      b.rem  = 18'(r);
      b.root = {a.root[14:0], 1'b0};
    end
    return b;
  endfunction

  function automatic div_t div_step(input div_t a, input logic [16:0] d);
    div_t        b;
    logic [17:0] r;
    r     = {a.rem, a.num[14]};
    b.num = {a.num[13:0], 1'b0};
    if (r >= {1'b0, d}) begin
      b.rem = 17'(r - {1'b0, d});
      b.q   = {a.q[13:0], 1'b1};
    end else begin
      b.rem = 17'(r);
      b.q   = {a.q[13:0], 1'b0};
    end
    return b;
  endfunction

  // drop FRAC_BITS, halves away from zero
  function automatic logic signed [ACC_W-1:0] round_fx(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    q   = (mag + HALF_FX) >> FRAC_BITS;
    return v[ACC_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [FX_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = round_fx(v);
    if (r > $signed(ONE_FX)) r = $signed(ONE_FX);
    if (r < -$signed(ONE_FX)) r = -$signed(ONE_FX);
    return FX_W'(r);
  endfunction

endpackage

// ===== rtl/align_z_rotation_matrix_unit.sv =====
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid/in_ready   | normal_x, normal_y, normal_z
// out     | output    | out_valid/out_ready | m00..m22, aligned
// cfg     | input     | cfg_wr_en           | aligned_threshold
//
// One word per cycle sustained while out_ready holds; from input accept to
// output valid a word passes the input reg, radicand load, 16 root steps,
// divisor load, 15 divide steps, then products, K^2 rounding, Rodrigues sums
// and final round/saturate (38 register stages, the first loaded at the accept edge).
// Reset (rst_n low, synchronous) clears all valid bits; threshold goes to 1.
// Stalls freeze the whole pipe: in_ready follows out_ready whenever the
// output register holds a word.
module align_z_rotation_matrix_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [azr_pkg::FX_W-1:0]       in_normal_x,
  input  logic signed [azr_pkg::FX_W-1:0]       in_normal_y,
  input  logic signed [azr_pkg::FX_W-1:0]       in_normal_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [azr_pkg::FX_W-1:0]       out_m00,
  output logic signed [azr_pkg::FX_W-1:0]       out_m01,
  output logic signed [azr_pkg::FX_W-1:0]       out_m02,
  output logic signed [azr_pkg::FX_W-1:0]       out_m10,
  output logic signed [azr_pkg::FX_W-1:0]       out_m11,
  output logic signed [azr_pkg::FX_W-1:0]       out_m12,
  output logic signed [azr_pkg::FX_W-1:0]       out_m20,
  output logic signed [azr_pkg::FX_W-1:0]       out_m21,
  output logic signed [azr_pkg::FX_W-1:0]       out_m22,
  output logic                                  out_aligned,
  input  logic                                  cfg_wr_en,
  input  logic [azr_pkg::THR_W-1:0]             cfg_wr_data
);
  import azr_pkg::*;

  logic             en;
  logic [THR_W-1:0] thr_r;

  // stage 0: input register, cosine saturated
  logic                   v0_r;
  logic signed [FX_W-1:0] nx0_r, ny0_r, c0_r;
  logic signed [FX_W-1:0] c_sat;

  // square-root pipe (index 0 = loaded radicands)
  logic                   sv_r  [0:SQ_STEPS];
  sqrt_t                  sql_r [0:SQ_STEPS];
  sqrt_t                  sqs_r [0:SQ_STEPS];
  logic signed [FX_W-1:0] snx_r [0:SQ_STEPS];
  logic signed [FX_W-1:0] sny_r [0:SQ_STEPS];
  logic signed [FX_W-1:0] sc_r  [0:SQ_STEPS];
  logic signed [31:0]     sq_nx, sq_ny, sq_c;

  // divider pipe: both axis components side by side
  logic                   dv_r  [0:DIV_STEPS];
  div_t                   d0_r  [0:DIV_STEPS];
  div_t                   d1_r  [0:DIV_STEPS];
  logic [16:0]            dd_r  [0:DIV_STEPS];
  logic                   dn0_r [0:DIV_STEPS];
  logic                   dn1_r [0:DIV_STEPS];
  logic                   dal_r [0:DIV_STEPS];
  logic [15:0]            ds_r  [0:DIV_STEPS];
  logic signed [FX_W-1:0] dc_r  [0:DIV_STEPS];
  logic [15:0]            mag0, mag1, len_w;
  logic [30:0]            num0, num1;
  logic                   al_w;

  // products
  logic                    p1v_r, p1al_r;
  logic signed [ACC_W-1:0] a0sq_r, a1sq_r, a01_r, sa0_r, sa1_r;
  logic signed [17:0]      omc1_r;
  logic signed [16:0]      a0_w, a1_w;
  logic signed [17:0]      s_w;

  // rounded K^2
  logic                    p2v_r, p2al_r;
  logic signed [16:0]      k00_r, k01_r, k11_r, k22_r;
  logic signed [ACC_W-1:0] sa0_2r, sa1_2r;
  logic signed [17:0]      omc2_r;

  // Rodrigues sums
  logic                    p3v_r, p3al_r;
  logic signed [ACC_W-1:0] acc00_r, acc01_r, acc02_r, acc11_r, acc12_r, acc22_r;

  // output register
  logic                   ov_r, oal_r;
  logic signed [FX_W-1:0] m00_r, m01_r, m02_r, m11_r, m12_r, m22_r;

  assign en       = !ov_r || out_ready;
  assign in_ready = en;

  always_comb begin
    c_sat = in_normal_z;
    if (in_normal_z > $signed(FX_W'(ONE_FX))) c_sat = FX_W'(ONE_FX);
    if (in_normal_z < -$signed(FX_W'(ONE_FX))) c_sat = -$signed(FX_W'(ONE_FX));
  end

  assign sq_nx = nx0_r * nx0_r;
  assign sq_ny = ny0_r * ny0_r;
  assign sq_c  = c0_r * c0_r;

  // axis is (-ny, nx)/len; dividend carries the rounding half
  assign len_w = sql_r[SQ_STEPS].root;
  assign mag0  = sny_r[SQ_STEPS][FX_W-1] ? 16'(-sny_r[SQ_STEPS]) : 16'(sny_r[SQ_STEPS]);
  assign mag1  = snx_r[SQ_STEPS][FX_W-1] ? 16'(-snx_r[SQ_STEPS]) : 16'(snx_r[SQ_STEPS]);
  assign num0  = {mag0, 15'b0} + 31'(len_w);
  assign num1  = {mag1, 15'b0} + 31'(len_w);
  assign al_w  = (sqs_r[SQ_STEPS].root < {1'b0, thr_r}) || (len_w == '0);

  assign a0_w = dn0_r[DIV_STEPS] ? -$signed({2'b00, d0_r[DIV_STEPS].q})
                                 :  $signed({2'b00, d0_r[DIV_STEPS].q});
  assign a1_w = dn1_r[DIV_STEPS] ? -$signed({2'b00, d1_r[DIV_STEPS].q})
                                 :  $signed({2'b00, d1_r[DIV_STEPS].q});
  assign s_w  = $signed({2'b00, ds_r[DIV_STEPS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      p3v_r <= 1'b0;
      ov_r  <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      v0_r  <= in_valid;
      sv_r[0] <= v0_r;
      for (int k = 1; k <= SQ_STEPS; k++) sv_r[k] <= sv_r[k-1];
      dv_r[0] <= sv_r[SQ_STEPS];
      for (int k = 1; k <= DIV_STEPS; k++) dv_r[k] <= dv_r[k-1];
      p1v_r <= dv_r[DIV_STEPS];
      p2v_r <= p1v_r;
      p3v_r <= p2v_r;
      ov_r  <= p3v_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      nx0_r <= in_normal_x;
      ny0_r <= in_normal_y;
      c0_r  <= c_sat;

      sql_r[0] <= '{x: 32'(sq_nx) + 32'(sq_ny), rem: '0, root: '0};
      sqs_r[0] <= '{x: 32'(ONE_SQ) - 32'(sq_c), rem: '0, root: '0};
      snx_r[0] <= nx0_r;
      sny_r[0] <= ny0_r;
      sc_r[0]  <= c0_r;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sql_r[k] <= sqrt_step(sql_r[k-1]);
        sqs_r[k] <= sqrt_step(sqs_r[k-1]);
        snx_r[k] <= snx_r[k-1];
        sny_r[k] <= sny_r[k-1];
        sc_r[k]  <= sc_r[k-1];
      end

      d0_r[0]  <= '{num: num0[14:0], rem: {1'b0, num0[30:15]}, q: '0};
      d1_r[0]  <= '{num: num1[14:0], rem: {1'b0, num1[30:15]}, q: '0};
      dd_r[0]  <= {len_w, 1'b0};
      dn0_r[0] <= !sny_r[SQ_STEPS][FX_W-1] && (sny_r[SQ_STEPS] != '0);
      dn1_r[0] <= snx_r[SQ_STEPS][FX_W-1];
      dal_r[0] <= al_w;
      ds_r[0]  <= sqs_r[SQ_STEPS].root;
      dc_r[0]  <= sc_r[SQ_STEPS];
      for (int k = 1; k <= DIV_STEPS; k++) begin
        d0_r[k]  <= div_step(d0_r[k-1], dd_r[k-1]);
        d1_r[k]  <= div_step(d1_r[k-1], dd_r[k-1]);
        dd_r[k]  <= dd_r[k-1];
        dn0_r[k] <= dn0_r[k-1];
        dn1_r[k] <= dn1_r[k-1];
        dal_r[k] <= dal_r[k-1];
        ds_r[k]  <= ds_r[k-1];
        dc_r[k]  <= dc_r[k-1];
      end

      a0sq_r <= ACC_W'(a0_w * a0_w);
      a1sq_r <= ACC_W'(a1_w * a1_w);
      a01_r  <= ACC_W'(a0_w * a1_w);
      sa0_r  <= ACC_W'(s_w * 18'(a0_w));
      sa1_r  <= ACC_W'(s_w * 18'(a1_w));
      omc1_r <= 18'(ONE_FX) - 18'(dc_r[DIV_STEPS]);
      p1al_r <= dal_r[DIV_STEPS];

      k00_r  <= -17'(round_fx(a1sq_r));
      k01_r  <=  17'(round_fx(a01_r));
      k11_r  <= -17'(round_fx(a0sq_r));
      k22_r  <= -17'(round_fx(a0sq_r + a1sq_r));
      sa0_2r <= sa0_r;
      sa1_2r <= sa1_r;
      omc2_r <= omc1_r;
      p2al_r <= p1al_r;

      acc00_r <= $signed(ONE_SQ) + ACC_W'(omc2_r * 18'(k00_r));
      acc01_r <= ACC_W'(omc2_r * 18'(k01_r));
      acc11_r <= $signed(ONE_SQ) + ACC_W'(omc2_r * 18'(k11_r));
      acc22_r <= $signed(ONE_SQ) + ACC_W'(omc2_r * 18'(k22_r));
      acc02_r <= sa1_2r;
      acc12_r <= -sa0_2r;
      p3al_r  <= p2al_r;

      oal_r <= p3al_r;
      if (p3al_r) begin
        m00_r <= FX_W'(ONE_FX);
        m01_r <= '0;
        m02_r <= '0;
        m11_r <= FX_W'(ONE_FX);
        m12_r <= '0;
        m22_r <= FX_W'(ONE_FX);
      end else begin
        m00_r <= round_sat(acc00_r);
        m01_r <= round_sat(acc01_r);
        m02_r <= round_sat(acc02_r);
        m11_r <= round_sat(acc11_r);
        m12_r <= round_sat(acc12_r);
        m22_r <= round_sat(acc22_r);
      end
    end
  end

  // K is skew-symmetric and K^2 symmetric, so the lower triangle mirrors
  assign out_valid   = ov_r;
  assign out_aligned = oal_r;
  assign out_m00     = m00_r;
  assign out_m01     = m01_r;
  assign out_m02     = m02_r;
  assign out_m10     = m01_r;
  assign out_m11     = m11_r;
  assign out_m12     = m12_r;
  assign out_m20     = -m02_r;
  assign out_m21     = -m12_r;
  assign out_m22     = m22_r;

  a_aligned_identity: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oal_r |-> m00_r == FX_W'(ONE_FX) && m02_r == '0 && m22_r == FX_W'(ONE_FX))
    else $error("aligned word is not identity");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> m00_r <= $signed(FX_W'(ONE_FX)) && m00_r >= -$signed(FX_W'(ONE_FX)) &&
             m22_r <= $signed(FX_W'(ONE_FX)) && m22_r >= -$signed(FX_W'(ONE_FX)))
    else $error("diagonal entry out of range");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(p3v_r) && $stable(dv_r[0]) && $stable(sv_r[0]))
    else $error("pipe moved during stall");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    en && p3v_r |=> ov_r)
    else $error("word lost at output register");

endmodule
